### hdl/averaged_level_scaler_assert.svh
// Assertion macros for the averaged level scaler.
// Used by the top level only; bodies are empty when SYNTHESIS is defined.
`ifndef AVERAGED_LEVEL_SCALER_ASSERT_SVH
`define AVERAGED_LEVEL_SCALER_ASSERT_SVH

`ifndef SYNTHESIS

// Condition holds at every edge outside reset.
`define ALS_ASSERT_HOLDS(lbl, clk, rst, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Consequent holds in the same cycle as the antecedent.
`define ALS_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define ALS_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`else

`define ALS_ASSERT_HOLDS(lbl, clk, rst, cond, msg)
`define ALS_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg)
`define ALS_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)

`endif

`endif

### hdl/als_pkg.sv
// Shared types and constants of the averaged level scaler.
// No dependencies; imported by the top level, the level checker and the testbench.
package als_pkg;

  localparam int READING_W   = 10;
  localparam int HEIGHT_W    = 15;
  localparam int PERCENT_TOP = 100;

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_EMPTY  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FULL   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_READ,
    ST_LAST,
    ST_MEAN_GO,
    ST_MEAN_WAIT,
    ST_MULT,
    ST_SCALE_GO,
    ST_SCALE_WAIT,
    ST_OUT
  } state_t;

endpackage

### hdl/als_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module als_ram #(
  parameter int WIDTH = 10,
  parameter int DEPTH = 10,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### hdl/als_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
// No package dependency; shared by the mean and the level map.
module als_div #(
  parameter int DVD_W = 27,
  parameter int DVS_W = 10
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DVS_W-1:0] divisor,
  output logic             done,
  output logic [DVD_W-1:0] quotient
);

  localparam int CW = $clog2(DVD_W + 1);

  logic             busy;
  logic [CW-1:0]    cnt;
  logic [DVS_W-1:0] rem;
  logic [DVS_W-1:0] dvs;
  logic [DVD_W-1:0] quo;
  logic [DVS_W:0]   trial;
  logic             fits;

  // Shift the next dividend bit into the partial remainder.
  assign trial = {rem, quo[DVD_W-1]};
  assign fits  = (trial >= {1'b0, dvs});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + CW'(1);
        if (cnt == CW'(DVD_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      dvs <= divisor;
      quo <= dividend;
    end else if (busy) begin
      rem <= fits ? DVS_W'(trial - {1'b0, dvs}) : trial[DVS_W-1:0];
      quo <= {quo[DVD_W-2:0], fits};
    end
  end

  assign quotient = quo;

endmodule

### hdl/averaged_level_scaler.sv
// Top level of the averaged level scaler: sample ring, mean, linear map, clamp.
// Depends on als_pkg, als_ram, als_div and averaged_level_scaler_assert.svh.
//
//   channel   direction   payload (low bits first)
//   s_*       in          tdata: sample
//   m_*       out         tdata: level, average; tuser: level_valid
//   cfg_*     in          cfg_index, cfg_data (0 empty, 1 full, 2 height)
//
// One sample at a time: fill_count ring reads, then two divisions on the
// shared bit-serial divider plus control states; the second division is
// skipped when empty equals full. A new sample is taken only in idle, once
// the last result has left ST_OUT. A result held by m_tready stalls in ST_OUT.
// Reset clears the control state and the configuration registers; ring entries are read
// only after being written, so no clearing pass is run.
// s_tready is high in idle even while a result waits on m_tready.
`include "averaged_level_scaler_assert.svh"

module averaged_level_scaler #(
  parameter int WINDOW      = 10,
  parameter int SAMPLE_BITS = 10,
  localparam int IN_W  = ((SAMPLE_BITS + 7) / 8) * 8,
  localparam int OUT_W = ((als_pkg::HEIGHT_W + SAMPLE_BITS + 7) / 8) * 8
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [IN_W-1:0]                s_tdata,    // sample
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [OUT_W-1:0]               m_tdata,    // level, average
  output logic                           m_tuser,    // level_valid
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [als_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [als_pkg::CFG_DATA_W-1:0] cfg_data
);

  import als_pkg::*;

  localparam int SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int CNT_W  = $clog2(WINDOW + 1);
  localparam int SUM_W  = SAMPLE_BITS + CNT_W;
  localparam int DIFF_W = ((SAMPLE_BITS > READING_W) ? SAMPLE_BITS : READING_W) + 2;
  localparam int NUM_W  = DIFF_W + HEIGHT_W + 1;
  localparam int MAG_W  = NUM_W - 1;
  localparam int DVD_W  = (SUM_W > MAG_W) ? SUM_W : MAG_W;
  localparam int DVS_W  = (READING_W > CNT_W) ? READING_W : CNT_W;

  state_t state;
  state_t state_next;

  logic [READING_W-1:0]   empty_reading;
  logic [READING_W-1:0]   full_reading;
  logic [HEIGHT_W-1:0]    tank_height;

  logic                   s_accept;
  logic                   out_free;
  logic [SLOT_W-1:0]      write_slot;
  logic [CNT_W-1:0]       fill_count;
  logic [SLOT_W-1:0]      rd_idx;
  logic                   rd_last;
  logic                   rd_vld;
  logic [SAMPLE_BITS-1:0] ring_rdata;
  logic [SUM_W-1:0]       sum;
  logic [SAMPLE_BITS-1:0] avg;
  logic [HEIGHT_W-1:0]    top;
  logic                   cal_equal;
  logic                   span_neg;
  logic [READING_W-1:0]   span_mag;
  logic signed [DIFF_W-1:0] diff;
  logic signed [NUM_W-1:0]  prod;
  logic signed [NUM_W-1:0]  num;
  logic [NUM_W-1:0]       num_abs;
  logic                   neg;
  logic [HEIGHT_W-1:0]    level_r;
  logic                   valid_r;

  logic                   div_start;
  logic [DVD_W-1:0]       div_dividend;
  logic [DVS_W-1:0]       div_divisor;
  logic                   div_done;
  logic [DVD_W-1:0]       div_quotient;

  assign s_accept  = s_tvalid && s_tready;
  assign out_free  = !m_tvalid || m_tready;
  assign cfg_ready = 1'b1;
  assign rd_last   = (CNT_W'(rd_idx) == fill_count - CNT_W'(1));

  assign top       = (tank_height != '0) ? tank_height : HEIGHT_W'(PERCENT_TOP);
  assign cal_equal = (empty_reading == full_reading);
  assign span_neg  = (full_reading < empty_reading);
  assign span_mag  = span_neg ? (empty_reading - full_reading)
                              : (full_reading - empty_reading);
  assign diff      = $signed(DIFF_W'(avg)) - $signed(DIFF_W'(empty_reading));
  assign prod      = NUM_W'(diff) * NUM_W'($signed({1'b0, top}));
  assign num_abs   = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
  assign neg       = num[NUM_W-1] ^ span_neg;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      empty_reading <= '0;
      full_reading  <= '0;
      tank_height   <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_EMPTY:  empty_reading <= cfg_data[READING_W-1:0];
        CFG_FULL:   full_reading  <= cfg_data[READING_W-1:0];
        CFG_HEIGHT: tank_height   <= cfg_data[HEIGHT_W-1:0];
        default: ;
      endcase
    end
  end

  als_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (WINDOW)
  ) u_ring (
    .clk   (clk),
    .we    (s_accept),
    .waddr (write_slot),
    .wdata (s_tdata[SAMPLE_BITS-1:0]),
    .raddr (rd_idx),
    .rdata (ring_rdata)
  );

  als_div #(
    .DVD_W (DVD_W),
    .DVS_W (DVS_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quotient)
  );

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:       if (s_accept) state_next = ST_READ;
      ST_READ:       if (rd_last) state_next = ST_LAST;
      ST_LAST:       state_next = ST_MEAN_GO;
      ST_MEAN_GO:    state_next = ST_MEAN_WAIT;
      ST_MEAN_WAIT:  if (div_done) state_next = cal_equal ? ST_OUT : ST_MULT;
      ST_MULT:       state_next = ST_SCALE_GO;
      ST_SCALE_GO:   state_next = ST_SCALE_WAIT;
      ST_SCALE_WAIT: if (div_done) state_next = ST_OUT;
      ST_OUT:        if (out_free) state_next = ST_IDLE;
      default:       state_next = ST_IDLE;
    endcase
  end

  // Outputs of the state machine
  always_comb begin
    s_tready     = (state == ST_IDLE);
    div_start    = (state == ST_MEAN_GO) || (state == ST_SCALE_GO);
    div_dividend = DVD_W'(sum);
    div_divisor  = DVS_W'(fill_count);
    if (state == ST_SCALE_GO) begin
      div_dividend = DVD_W'(num_abs);
      div_divisor  = DVS_W'(span_mag);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      write_slot <= '0;
      fill_count <= '0;
      rd_vld     <= 1'b0;
      m_tvalid   <= 1'b0;
    end else begin
      state  <= state_next;
      rd_vld <= (state == ST_READ);
      if (s_accept) begin
        write_slot <= (write_slot == SLOT_W'(WINDOW - 1)) ? '0 : write_slot + SLOT_W'(1);
        if (fill_count != CNT_W'(WINDOW)) begin
          fill_count <= fill_count + CNT_W'(1);
        end
      end
      if (state == ST_OUT && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // Ring sweep and datapath registers
  always_ff @(posedge clk) begin
    if (s_accept) begin
      rd_idx <= '0;
      sum    <= '0;
    end else begin
      if (state == ST_READ && !rd_last) begin
        rd_idx <= rd_idx + SLOT_W'(1);
      end
      if (rd_vld) begin
        sum <= sum + SUM_W'(ring_rdata);
      end
    end

    if (state == ST_MEAN_WAIT && div_done) begin
      avg     <= div_quotient[SAMPLE_BITS-1:0];
      level_r <= '0;
      valid_r <= 1'b0;
    end

    if (state == ST_MULT) begin
      num <= prod;
    end

    // Clamp to [0, top]
    if (state == ST_SCALE_WAIT && div_done) begin
      valid_r <= 1'b1;
      priority if (neg) begin
        level_r <= '0;
      end else if (div_quotient > DVD_W'(top)) begin
        level_r <= top;
      end else begin
        level_r <= div_quotient[HEIGHT_W-1:0];
      end
    end

    if (state == ST_OUT && out_free) begin
      m_tdata <= OUT_W'({avg, level_r});
      m_tuser <= valid_r;
    end
  end

  `ALS_ASSERT_HOLDS(a_slot_in_range, clk, rst, write_slot <= SLOT_W'(WINDOW - 1), "write slot out of range")
  `ALS_ASSERT_IMPL(a_fill_nonzero, clk, rst, state != ST_IDLE, fill_count != '0 && fill_count <= CNT_W'(WINDOW), "fill count out of range while busy")
  `ALS_ASSERT_NEXT(a_accept_starts_sweep, clk, rst, s_tvalid && s_tready, state == ST_READ && rd_idx == '0 && sum == '0, "sweep not started after input transfer")
  `ALS_ASSERT_IMPL(a_invalid_level_zero, clk, rst, m_tvalid && !m_tuser, m_tdata[HEIGHT_W-1:0] == '0, "level nonzero while not valid")

endmodule

### verif/als_level_check.sv
// Level checker for the averaged level scaler: watches the sample, result and
// calibration channels, predicts each result and compares it field by field.
// Depends on als_pkg for widths and register indexes.
module als_level_check #(
  parameter int WINDOW      = 10,
  parameter int SAMPLE_BITS = 10,
  parameter int IN_W        = 16,
  parameter int OUT_W       = 32
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  input  logic                           s_tready,
  input  logic [IN_W-1:0]                s_tdata,
  input  logic                           m_tvalid,
  input  logic                           m_tready,
  input  logic [OUT_W-1:0]               m_tdata,
  input  logic                           m_tuser,
  input  logic                           cfg_valid,
  input  logic                           cfg_ready,
  input  logic [als_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [als_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                             mismatches,
  output int                             outstanding
);
  timeunit 1ns;
  timeprecision 1ps;
  import als_pkg::*;

  typedef struct packed {
    logic [HEIGHT_W-1:0]    level;
    logic                   level_valid;
    logic [SAMPLE_BITS-1:0] average;
  } level_result_t;

  level_result_t          expected_levels[$];
  level_result_t          got, want;
  logic [SAMPLE_BITS-1:0] sample_hist[WINDOW];
  int                     next_slot;
  int                     stored;
  logic [READING_W-1:0]   empty_cal, full_cal;
  logic [HEIGHT_W-1:0]    height_cal;

  // Store the sample, then average and map the window as it stands.
  function automatic level_result_t scale_sample(input logic [SAMPLE_BITS-1:0] s);
    level_result_t r;
    longint        sum, top, span, num, lvl;
    sample_hist[next_slot] = s;
    next_slot = (next_slot + 1) % WINDOW;
    if (stored < WINDOW) stored++;
    sum = 0;
    for (int i = 0; i < stored; i++) sum += sample_hist[i];
    r.average = SAMPLE_BITS'(sum / stored);
    lvl = 0;
    r.level_valid = 1'b0;
    if (empty_cal != full_cal) begin
      top  = (height_cal != 0) ? longint'(height_cal) : longint'(PERCENT_TOP);
      span = longint'(full_cal) - longint'(empty_cal);
      num  = (longint'(r.average) - longint'(empty_cal)) * top;
      // SV division truncates toward zero; a negative span inverts the scale
      lvl  = num / span;
      if (lvl < 0) lvl = 0;
      if (lvl > top) lvl = top;
      r.level_valid = 1'b1;
    end
    r.level = HEIGHT_W'(lvl);
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      expected_levels.delete();
      next_slot  = 0;
      stored     = 0;
      empty_cal  = '0;
      full_cal   = '0;
      height_cal = '0;
      mismatches = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_EMPTY:  empty_cal  = cfg_data[READING_W-1:0];
          CFG_FULL:   full_cal   = cfg_data[READING_W-1:0];
          CFG_HEIGHT: height_cal = cfg_data[HEIGHT_W-1:0];
          default: ;
        endcase
      end
      if (m_tvalid && m_tready) begin
        got.level       = m_tdata[HEIGHT_W-1:0];
        got.level_valid = m_tuser;
        got.average     = m_tdata[HEIGHT_W +: SAMPLE_BITS];
        if (expected_levels.size() == 0) begin
          $display("%0t: result with none expected: level %0d valid %0b average %0d",
                   $time, got.level, got.level_valid, got.average);
          mismatches++;
        end else begin
          want = expected_levels.pop_front();
          if (got.level !== want.level) begin
            $display("%0t: level expected %0d got %0d", $time, want.level, got.level);
            mismatches++;
          end
          if (got.level_valid !== want.level_valid) begin
            $display("%0t: level_valid expected %0b got %0b",
                     $time, want.level_valid, got.level_valid);
            mismatches++;
          end
          if (got.average !== want.average) begin
            $display("%0t: average expected %0d got %0d", $time, want.average, got.average);
            mismatches++;
          end
        end
      end
      if (s_tvalid && s_tready)
        expected_levels.push_back(scale_sample(s_tdata[SAMPLE_BITS-1:0]));
    end
    outstanding = expected_levels.size();
  end

endmodule

### verif/averaged_level_scaler_tb.sv
// Top of the averaged level scaler testbench: clock, reset, sample and
// calibration stimulus, result back-pressure and the verdict.
// Depends on als_pkg, the scaler RTL and als_level_check.
module averaged_level_scaler_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import als_pkg::*;

  localparam int WINDOW        = 10;
  localparam int SAMPLE_BITS   = 10;
  localparam int IN_W          = ((SAMPLE_BITS + 7) / 8) * 8;
  localparam int OUT_W         = ((HEIGHT_W + SAMPLE_BITS + 7) / 8) * 8;
  localparam int SAMPLE_MAX    = (1 << SAMPLE_BITS) - 1;
  localparam int READING_MAX   = (1 << READING_W) - 1;
  localparam int HEIGHT_MAX    = (1 << HEIGHT_W) - 1;
  localparam int IDLE_LIMIT    = 4000;
  localparam int HOLD_CYCLES   = 600;
  localparam int DRAIN_CYCLES  = 200;
  localparam int RANDOM_PHASES = 12;
  localparam int PHASE_ITEMS   = 38;

  // Index past the register list; the block drops writes to it
  localparam logic [CFG_IDX_W-1:0] CFG_NONE = 2'd3;

  logic                  clk;
  logic                  rst;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [IN_W-1:0]       s_tdata;    // sample
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_W-1:0]      m_tdata;    // level, average
  logic                  m_tuser;    // level_valid
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  int   mismatches;
  int   outstanding;
  int   burst_left  = 0;
  int   rx_mode     = 0;
  int   rx_left     = 0;
  int   hold_left   = 0;
  int   idle_cycles = 0;
  logic hold_req    = 1'b0;
  logic hold_taken  = 1'b0;

  averaged_level_scaler #(
    .WINDOW      (WINDOW),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_top (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  als_level_check #(
    .WINDOW      (WINDOW),
    .SAMPLE_BITS (SAMPLE_BITS),
    .IN_W        (IN_W),
    .OUT_W       (OUT_W)
  ) u_level_check (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tuser     (m_tuser),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Result side: modes of free flow, random stalls and sparse accepts,
  // plus one long hold-off when requested.
  always @(negedge clk) begin
    if (hold_req && !hold_taken) begin
      hold_taken = 1'b1;
      hold_left  = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else begin
      if (rx_left == 0) begin
        rx_mode = $urandom_range(0, 2);
        rx_left = $urandom_range(16, 200);
      end
      rx_left--;
      case (rx_mode)
        0:       m_tready <= 1'b1;
        1:       m_tready <= 1'($urandom_range(0, 1));
        default: m_tready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, idle_cycles);
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Offer one sample; keep tvalid high across a burst, drop it for a gap.
  task automatic send(input int v);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 90);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 16);
    end
    s_tdata  <= IN_W'(SAMPLE_BITS'(v));
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
    burst_left--;
  endtask

  // Write one register with junk above its width; leaves cfg_valid high.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
    logic [CFG_DATA_W-1:0] junk;
    logic [CFG_DATA_W-1:0] word;
    junk = CFG_DATA_W'($urandom());
    word = CFG_DATA_W'(value);
    if (idx == CFG_HEIGHT)
      word[CFG_DATA_W-1:HEIGHT_W] = junk[CFG_DATA_W-1:HEIGHT_W];
    else if (idx != CFG_NONE)
      word[CFG_DATA_W-1:READING_W] = junk[CFG_DATA_W-1:READING_W];
    cfg_index <= idx;
    cfg_data  <= word;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
  endtask

  task automatic set_cal(input int e, input int f, input int h);
    write_reg(CFG_EMPTY, e);
    write_reg(CFG_FULL, f);
    write_reg(CFG_HEIGHT, h);
    cfg_valid <= 1'b0;
  endtask

  // Stop offering and wait for every pending result.
  task automatic settle();
    s_tvalid <= 1'b0;
    burst_left = 0;
    while (outstanding != 0) @(negedge clk);
  endtask

  function automatic int clip_reading(input int v);
    return (v < 0) ? 0 : (v > SAMPLE_MAX) ? SAMPLE_MAX : v;
  endfunction

  // Samples over the whole range or inside the calibration span, some at or beyond its edges.
  function automatic int pick_sample(input int e, input int f);
    int lo, hi;
    lo = (e < f) ? e : f;
    hi = (e < f) ? f : e;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return $urandom_range(0, SAMPLE_MAX);
      4, 5, 6, 7: return $urandom_range(lo, hi);
      8:          return $urandom_range(0, 1) ? SAMPLE_MAX : 0;
      default:    return clip_reading(($urandom_range(0, 1) ? lo : hi)
                                      + $urandom_range(0, 10) - 5);
    endcase
  endfunction

  initial begin
    int e, f, h;
    rst       = 1'b1;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    cfg_valid = 1'b0;
    cfg_index = CFG_EMPTY;
    cfg_data  = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Reset calibration: empty equals full, so no level
    send(0);
    send(SAMPLE_MAX);
    send(0);
    settle();
    // Mean below a narrow span: clamp at zero percent
    set_cal(1000, 1010, 0);
    send(512);
    send(SAMPLE_MAX);
    settle();
    // Mean above the span: clamp at full height
    set_cal(0, 5, HEIGHT_MAX);
    send(SAMPLE_MAX);
    send(700);
    settle();
    // Full below empty: inverted scale
    set_cal(READING_MAX, 0, 250);
    send(0);
    send(SAMPLE_MAX);
    send(300);
    send(800);
    settle();
    // Widest span and tallest tank; the ring has already wrapped before here
    set_cal(0, READING_MAX, HEIGHT_MAX);
    repeat (4) send(SAMPLE_MAX);
    send(0);
    settle();
    // Equal calibration with a height set
    set_cal(600, 600, 77);
    send(600);
    send(5);
    settle();
    // Write past the register list, then percent over the full range
    write_reg(CFG_NONE, CFG_DATA_W'('1));
    set_cal(0, READING_MAX, 0);
    send(SAMPLE_MAX);
    send(0);
    send(555);
    settle();

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case ($urandom_range(0, 5))
        0:       e = 0;
        1:       e = READING_MAX;
        default: e = $urandom_range(0, READING_MAX);
      endcase
      case ($urandom_range(0, 5))
        0:       f = e;
        1:       f = READING_MAX - e;
        2:       f = clip_reading(e + $urandom_range(0, 20) - 10);
        default: f = $urandom_range(0, READING_MAX);
      endcase
      case ($urandom_range(0, 7))
        0, 1:    h = 0;
        2:       h = HEIGHT_MAX;
        3:       h = $urandom_range(1, 10);
        default: h = $urandom_range(1, HEIGHT_MAX);
      endcase
      if ($urandom_range(0, 3) == 0) write_reg(CFG_NONE, $urandom_range(0, HEIGHT_MAX));
      set_cal(e, f, h);
      // Stall the result side long enough to back up the sample side
      if (p == RANDOM_PHASES / 2) hold_req <= 1'b1;
      repeat (PHASE_ITEMS) send(pick_sample(e, f));
      settle();
    end

    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatches == 0 && outstanding == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule
